// File: rtl/core/rgb_to_hsv_pixel_assert.svh
// Assertion macros for the RGB to HSV pixel converter.
// Used by the port checker; relies on nothing else.
`ifndef RGB_TO_HSV_PIXEL_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define RHP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rgb_to_hsv_pixel: same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define RHP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rgb_to_hsv_pixel: next-cycle check failed");

`endif

// File: rtl/core/rhp_pkg.sv
// Shared types, widths and constants for the RGB to HSV pixel converter.
// No dependencies.
`default_nettype none

package rhp_pkg;

    // Field widths
    localparam int CH_W  = 8;
    localparam int HUE_W = 15;
    localparam int SAT_W = 13;

    // Divider geometry: 8-bit divisor, 13 quotient bits, 21-bit dividend
    localparam int DIV_DW = 8;
    localparam int DIV_QW = 13;
    localparam int DIV_NW = DIV_DW + DIV_QW;

    // Hue offsets in degrees times 64
    localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_BLUE  = 15'd15360;
    localparam logic [HUE_W-1:0] HUE_FULL  = 15'd23040;

    // Which offset the hue sector adds to
    typedef enum logic [1:0] {
        HB_ZERO,
        HB_GREEN,
        HB_BLUE,
        HB_FULL
    } t_hue_base;

    // Per-pixel control travelling beside the dividers
    typedef struct packed {
        logic             valid;
        logic             gray;
        logic             black;
        logic             neg;
        t_hue_base        base;
        logic [CH_W-1:0]  value;
    } t_pix_ctl;

    // Front end output: control plus both division requests
    typedef struct packed {
        t_pix_ctl            ctl;
        logic [DIV_NW-1:0]   hue_num;
        logic [DIV_DW-1:0]   hue_den;
        logic [DIV_NW-1:0]   sat_num;
        logic [DIV_DW-1:0]   sat_den;
    } t_front;

    function automatic logic [HUE_W-1:0] hue_base(input t_hue_base code);
        logic [HUE_W-1:0] v;
        unique case (code)
            HB_ZERO:  v = '0;
            HB_GREEN: v = HUE_GREEN;
            HB_BLUE:  v = HUE_BLUE;
            HB_FULL:  v = HUE_FULL;
            default:  v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/rhp_front.sv
// Input register and channel analysis: max, min, range, hue sector and
// the two division requests. Depends on rhp_pkg.
`default_nettype none

module rhp_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic [rhp_pkg::CH_W-1:0] i_red,
    input  wire logic [rhp_pkg::CH_W-1:0] i_green,
    input  wire logic [rhp_pkg::CH_W-1:0] i_blue,
    output rhp_pkg::t_front               o_front
);

    logic                     r_valid;
    logic [rhp_pkg::CH_W-1:0] r_red;
    logic [rhp_pkg::CH_W-1:0] r_green;
    logic [rhp_pkg::CH_W-1:0] r_blue;

    logic                     w_red_max;
    logic                     w_green_max;
    logic [rhp_pkg::CH_W-1:0] w_max;
    logic [rhp_pkg::CH_W-1:0] w_min;
    logic [rhp_pkg::CH_W-1:0] w_range;
    logic [rhp_pkg::CH_W:0]   w_d_gb;
    logic [rhp_pkg::CH_W:0]   w_d_br;
    logic [rhp_pkg::CH_W:0]   w_d_rg;
    logic [rhp_pkg::CH_W:0]   w_num;
    logic [rhp_pkg::CH_W:0]   w_mag9;
    logic [rhp_pkg::CH_W-1:0] w_mag;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
    end

    // Sector pick: red wins ties, then green
    assign w_red_max   = (r_red >= r_green) && (r_red >= r_blue);
    assign w_green_max = !w_red_max && (r_green >= r_blue);

    assign w_max = w_red_max ? r_red : (w_green_max ? r_green : r_blue);
    assign w_min = ((r_red <= r_green) && (r_red <= r_blue)) ? r_red :
                   ((r_green <= r_blue) ? r_green : r_blue);
    assign w_range = w_max - w_min;

    // Signed channel differences, one per sector
    assign w_d_gb = {1'b0, r_green} - {1'b0, r_blue};
    assign w_d_br = {1'b0, r_blue}  - {1'b0, r_red};
    assign w_d_rg = {1'b0, r_red}   - {1'b0, r_green};
    assign w_num  = w_red_max ? w_d_gb : (w_green_max ? w_d_br : w_d_rg);
    assign w_mag9 = w_num[rhp_pkg::CH_W] ? (~w_num + 1'b1) : w_num;
    assign w_mag  = w_mag9[rhp_pkg::CH_W-1:0];

    always_comb begin
        o_front.ctl.valid = r_valid;
        o_front.ctl.gray  = (w_range == '0);
        o_front.ctl.black = (w_max == '0);
        o_front.ctl.neg   = w_num[rhp_pkg::CH_W];
        o_front.ctl.value = w_max;
        if (w_red_max) begin
            o_front.ctl.base = w_num[rhp_pkg::CH_W] ? rhp_pkg::HB_FULL : rhp_pkg::HB_ZERO;
        end else if (w_green_max) begin
            o_front.ctl.base = rhp_pkg::HB_GREEN;
        end else begin
            o_front.ctl.base = rhp_pkg::HB_BLUE;
        end
        // 3840 * mag = mag * 4096 - mag * 256
        o_front.hue_num = {1'b0, w_mag, 12'b0} - {5'b0, w_mag, 8'b0};
        o_front.hue_den = w_range;
        o_front.sat_num = {1'b0, w_range, 12'b0};
        o_front.sat_den = w_max;
    end

endmodule

`default_nettype wire

// File: rtl/core/rhp_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Dividend must be below divisor * 2**DIV_QW. Depends on rhp_pkg.
`default_nettype none

module rhp_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [rhp_pkg::DIV_NW-1:0]  i_num,
    input  wire logic [rhp_pkg::DIV_DW-1:0]  i_den,
    output logic      [rhp_pkg::DIV_QW-1:0]  o_quo,
    output logic      [rhp_pkg::DIV_DW-1:0]  o_rem
);

    localparam int QW = rhp_pkg::DIV_QW;
    localparam int DW = rhp_pkg::DIV_DW;

    // Partial remainder, dividend bits shifting out / quotient bits in, divisor
    logic [DW-1:0] r_rem [0:QW];
    logic [QW-1:0] r_lo  [0:QW];
    logic [DW-1:0] r_den [0:QW];

    // Stage 0 load: upper dividend bits seed the remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num[rhp_pkg::DIV_NW-1:QW];
            r_lo[0]  <= i_num[QW-1:0];
            r_den[0] <= i_den;
        end
    end

    // One compare and subtract per stage
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0]   w_t;
        logic [DW:0]   w_sub;
        logic          w_ge;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_lo;

        assign w_t   = {r_rem[k], r_lo[k][QW-1]};
        assign w_sub = w_t - {1'b0, r_den[k]};
        assign w_ge  = (w_t >= {1'b0, r_den[k]});
        assign n_rem = w_ge ? w_sub[DW-1:0] : w_t[DW-1:0];
        assign n_lo  = {r_lo[k][QW-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_rem;
                r_lo[k+1]  <= n_lo;
                r_den[k+1] <= r_den[k];
            end
        end
    end

    assign o_quo = r_lo[QW];
    assign o_rem = r_rem[QW];

endmodule

`default_nettype wire

// File: rtl/core/rhp_out.sv
// Result assembly (hue offset and rounding, special cases), output
// register and skid entry. Depends on rhp_pkg.
`default_nettype none

module rhp_out (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rhp_pkg::t_pix_ctl           i_ctl,
    input  wire logic [rhp_pkg::DIV_QW-1:0]  i_hue_quo,
    input  wire logic [rhp_pkg::DIV_DW-1:0]  i_hue_rem,
    input  wire logic [rhp_pkg::DIV_QW-1:0]  i_sat_quo,
    input  wire logic                        i_stall,
    output logic                             o_en,
    output logic                             o_valid,
    output logic      [rhp_pkg::HUE_W-1:0]   o_hue,
    output logic      [rhp_pkg::SAT_W-1:0]   o_saturation,
    output logic      [rhp_pkg::CH_W-1:0]    o_value
);

    localparam int HW = rhp_pkg::HUE_W;
    localparam int SW = rhp_pkg::SAT_W;
    localparam int CW = rhp_pkg::CH_W;

    logic          r_out_valid;
    logic [HW-1:0] r_out_hue;
    logic [SW-1:0] r_out_sat;
    logic [CW-1:0] r_out_val;
    logic          r_skid_valid;
    logic [HW-1:0] r_skid_hue;
    logic [SW-1:0] r_skid_sat;
    logic [CW-1:0] r_skid_val;

    logic [rhp_pkg::DIV_QW-1:0] w_ceil;
    logic [HW-1:0]              w_base;
    logic [HW-1:0]              w_hue;
    logic [SW-1:0]              w_sat;
    logic                       w_take;

    // Negative sectors round toward minus infinity: subtract the ceiling
    assign w_ceil = i_hue_quo + {{(rhp_pkg::DIV_QW-1){1'b0}}, (i_hue_rem != '0)};
    assign w_base = rhp_pkg::hue_base(i_ctl.base);

    always_comb begin
        if (i_ctl.gray) begin
            w_hue = '0;
        end else if (i_ctl.neg) begin
            w_hue = w_base - {{(HW-rhp_pkg::DIV_QW){1'b0}}, w_ceil};
        end else begin
            w_hue = w_base + {{(HW-rhp_pkg::DIV_QW){1'b0}}, i_hue_quo};
        end
        w_sat = i_ctl.black ? '0 : i_sat_quo[SW-1:0];
    end

    // Pipeline moves only while the skid entry is free
    assign o_en   = !r_skid_valid;
    assign w_take = r_out_valid && !i_stall;

    // Output and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_ctl.valid) begin
            if (r_out_valid && !w_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output and skid payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out_hue <= r_skid_hue;
                r_out_sat <= r_skid_sat;
                r_out_val <= r_skid_val;
            end
        end else if (i_ctl.valid) begin
            if (r_out_valid && !w_take) begin
                r_skid_hue <= w_hue;
                r_skid_sat <= w_sat;
                r_skid_val <= i_ctl.value;
            end else begin
                r_out_hue <= w_hue;
                r_out_sat <= w_sat;
                r_out_val <= i_ctl.value;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hue        = r_out_hue;
    assign o_saturation = r_out_sat;
    assign o_value      = r_out_val;

endmodule

`default_nettype wire

// File: rtl/core/rgb_to_hsv_pixel.sv
// Top level of the RGB to HSV pixel converter.
// Depends on rhp_pkg, rhp_front, rhp_div and rhp_out.
//
//   channel   valid     stall     payload
//   input     i_valid   o_stall   i_red, i_green, i_blue
//   output    o_valid   i_stall   o_hue, o_saturation, o_value
//
// One pixel request per clock while o_stall is low; each taken request passes
// through the input register (loaded at the accepting edge), then the
// divider load stage, 13 divider bit stages and the output register.
// Hue and saturation come from two 13-stage restoring dividers in parallel.
// A skid entry at the output catches one result when the output stalls;
// while it is full the whole pipeline holds and o_stall is high.
// Synchronous reset clears the valid bits only.
`default_nettype none

module rgb_to_hsv_pixel (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [rhp_pkg::CH_W-1:0]  i_red,
    input  wire logic [rhp_pkg::CH_W-1:0]  i_green,
    input  wire logic [rhp_pkg::CH_W-1:0]  i_blue,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic      [rhp_pkg::HUE_W-1:0] o_hue,
    output logic      [rhp_pkg::SAT_W-1:0] o_saturation,
    output logic      [rhp_pkg::CH_W-1:0]  o_value
);

    localparam int QW = rhp_pkg::DIV_QW;

    logic                       w_en;
    rhp_pkg::t_front            w_front;
    logic [QW-1:0]              w_hue_quo;
    logic [rhp_pkg::DIV_DW-1:0] w_hue_rem;
    logic [QW-1:0]              w_sat_quo;
    logic [rhp_pkg::DIV_DW-1:0] w_sat_rem;

    // Control delay line beside the dividers
    rhp_pkg::t_pix_ctl r_ctl [0:QW];

    assign o_stall = !w_en;

    rhp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_front (w_front)
    );

    rhp_div u_hue_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_front.hue_num),
        .i_den (w_front.hue_den),
        .o_quo (w_hue_quo),
        .o_rem (w_hue_rem)
    );

    rhp_div u_sat_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_front.sat_num),
        .i_den (w_front.sat_den),
        .o_quo (w_sat_quo),
        .o_rem (w_sat_rem)
    );

    // Valid bits reset; the rest is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_ctl[k].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_ctl[0] <= w_front.ctl;
            for (int k = 1; k <= QW; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    // Saturation remainder is not needed: truncation is the floor
    rhp_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (r_ctl[QW]),
        .i_hue_quo    (w_hue_quo),
        .i_hue_rem    (w_hue_rem),
        .i_sat_quo    (w_sat_quo | {QW{1'b0 & (|w_sat_rem)}}),
        .i_stall      (i_stall),
        .o_en         (w_en),
        .o_valid      (o_valid),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_value      (o_value)
    );

endmodule

`default_nettype wire

// File: rtl/core/rhp_chk.sv
// Port-level checker for the RGB to HSV pixel converter, bound to the
// top level. Uses the macros in rgb_to_hsv_pixel_assert.svh.
`default_nettype none

`include "rgb_to_hsv_pixel_assert.svh"

module rhp_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [14:0] o_hue,
    input wire logic [12:0] o_saturation,
    input wire logic [7:0]  o_value
);

    // A stalled result stays put
    `RHP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_hue) && $stable(o_saturation) && $stable(o_value))

    // Hue stays below a full turn
    `RHP_ASSERT_IMP(a_hue_range, i_clk, i_rst_n, o_valid, o_hue <= 15'd23039)

    // Saturation never exceeds one
    `RHP_ASSERT_IMP(a_sat_range, i_clk, i_rst_n, o_valid, o_saturation <= 13'd4096)

    // Zero saturation only for gray or black, both of which have hue 0
    `RHP_ASSERT_IMP(a_gray_hue, i_clk, i_rst_n, o_valid && (o_saturation == 13'd0), o_hue == 15'd0)

endmodule

bind rgb_to_hsv_pixel rhp_chk u_rhp_chk (.*);

`default_nettype wire
